/* rtl/core/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, constants and helper functions shared by the JSON string unescape
// front end, command queue and result back end.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Input item: one raw byte of the string body, or an end-of-stream mark.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_item_t;

  // Result item: one decoded byte, a string-closed mark or a parse error.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
  } out_item_t;

  // Result kinds.
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_CLOSED = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Decoder modes.
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_HEX    = 2'd2
  } mode_t;

  // Commands passed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_UTF8   = 2'd1,
    OP_CLOSED = 2'd2,
    OP_ERROR  = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [15:0] cp;
  } cmd_t;

  // Characters with a special meaning in a string body.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6e;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Bytes produced by the single-character escapes.
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_FF  = 8'h0c;
  localparam logic [7:0] BYTE_LF  = 8'h0a;
  localparam logic [7:0] BYTE_CR  = 8'h0d;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  // UTF-8 encoding limits and marker bits.
  localparam logic [15:0] UTF8_LIM1  = 16'h0080;
  localparam logic [15:0] UTF8_LIM2  = 16'h0800;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hc0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'he0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;

  // Value of a hex digit; 16 when the byte is not a hex digit.
  function automatic logic [4:0] hex_value(logic [7:0] b);
    logic [7:0] v;
    v = 8'd16;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h57;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = b - 8'h37;
    end
    return v[4:0];
  endfunction

  // Number of result items a command expands into.
  function automatic logic [1:0] cmd_len(cmd_t c);
    logic [1:0] n;
    n = 2'd1;
    if (c.op == OP_UTF8) begin
      if (c.cp < UTF8_LIM1) begin
        n = 2'd1;
      end else if (c.cp < UTF8_LIM2) begin
        n = 2'd2;
      end else begin
        n = 2'd3;
      end
    end
    return n;
  endfunction

  // Result kind of a command.
  function automatic logic [1:0] cmd_kind(cmd_t c);
    logic [1:0] k;
    unique case (c.op)
      OP_CLOSED: k = KIND_CLOSED;
      OP_ERROR:  k = KIND_ERROR;
      default:   k = KIND_DATA;
    endcase
    return k;
  endfunction

  // Byte number idx of the expansion of a command.
  function automatic logic [7:0] cmd_byte(cmd_t c, logic [1:0] idx);
    logic [7:0] b;
    b = 8'd0;
    unique case (c.op)
      OP_BYTE: b = c.cp[7:0];
      OP_UTF8: begin
        if (c.cp < UTF8_LIM1) begin
          b = c.cp[7:0];
        end else if (c.cp < UTF8_LIM2) begin
          if (idx == 2'd0) begin
            b = UTF8_LEAD2 | {3'b000, c.cp[10:6]};
          end else begin
            b = UTF8_CONT | {2'b00, c.cp[5:0]};
          end
        end else begin
          if (idx == 2'd0) begin
            b = UTF8_LEAD3 | {4'b0000, c.cp[15:12]};
          end else if (idx == 2'd1) begin
            b = UTF8_CONT | {2'b00, c.cp[11:6]};
          end else begin
            b = UTF8_CONT | {2'b00, c.cp[5:0]};
          end
        end
      end
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

/* rtl/core/jsu_front.sv */
// ----------------------------------------------------------------------------
// jsu_front
// Accepts raw string bytes, tracks the escape mode and hex digits, and turns
// each item that causes results into one command for the back end.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t raw,
  input  logic     q_full,
  output logic     q_wr,
  output cmd_t     q_cmd
);

  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [11:0] code_accum, code_accum_next;
  logic        accept;
  logic [4:0]  digit;
  logic [7:0]  b;

  assign accept = push && !q_full;
  assign b      = raw.in_byte;
  assign digit  = hex_value(b);

  // Next state of the mode, digit count and accumulated code.
  always_comb begin
    mode_next       = mode;
    hex_count_next  = hex_count;
    code_accum_next = code_accum;
    if (accept) begin
      mode_next       = MODE_NORMAL;
      hex_count_next  = 2'd0;
      code_accum_next = 12'd0;
      if (!raw.stream_end) begin
        unique case (mode)
          MODE_ESC: begin
            if (b == CH_LC_U) begin
              mode_next = MODE_HEX;
            end
          end
          MODE_HEX: begin
            if (!digit[4] && hex_count != 2'd3) begin
              mode_next       = MODE_HEX;
              hex_count_next  = hex_count + 2'd1;
              code_accum_next = {code_accum[7:0], digit[3:0]};
            end
          end
          default: begin
            if (b == CH_BSLASH) begin
              mode_next = MODE_ESC;
            end
          end
        endcase
      end
    end
  end

  // Command written to the queue for the accepted item.
  always_comb begin
    q_wr     = 1'b0;
    q_cmd.op = OP_ERROR;
    q_cmd.cp = 16'd0;
    if (accept) begin
      q_wr = 1'b1;
      if (raw.stream_end) begin
        q_cmd.op = OP_ERROR;
      end else begin
        unique case (mode)
          MODE_ESC: begin
            q_cmd.op = OP_BYTE;
            unique case (b)
              CH_QUOTE:  q_cmd.cp = {8'd0, CH_QUOTE};
              CH_BSLASH: q_cmd.cp = {8'd0, CH_BSLASH};
              CH_SLASH:  q_cmd.cp = {8'd0, CH_SLASH};
              CH_LC_B:   q_cmd.cp = {8'd0, BYTE_BS};
              CH_LC_F:   q_cmd.cp = {8'd0, BYTE_FF};
              CH_LC_N:   q_cmd.cp = {8'd0, BYTE_LF};
              CH_LC_R:   q_cmd.cp = {8'd0, BYTE_CR};
              CH_LC_T:   q_cmd.cp = {8'd0, BYTE_TAB};
              CH_LC_U:   q_wr = 1'b0;
              default:   q_cmd.op = OP_ERROR;
            endcase
          end
          MODE_HEX: begin
            if (digit[4]) begin
              q_cmd.op = OP_ERROR;
            end else if (hex_count != 2'd3) begin
              q_wr = 1'b0;
            end else begin
              q_cmd.op = OP_UTF8;
              q_cmd.cp = {code_accum, digit[3:0]};
            end
          end
          default: begin
            if (b == CH_QUOTE) begin
              q_cmd.op = OP_CLOSED;
            end else if (b == CH_BSLASH) begin
              q_wr = 1'b0;
            end else if (b < CH_SPACE || b == CH_DEL) begin
              q_cmd.op = OP_ERROR;
            end else begin
              q_cmd.op = OP_BYTE;
              q_cmd.cp = {8'd0, b};
            end
          end
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      hex_count  <= 2'd0;
      code_accum <= 12'd0;
    end else begin
      mode       <= mode_next;
      hex_count  <= hex_count_next;
      code_accum <= code_accum_next;
    end
  end

  // The digit count only runs while hex digits are being read.
  a_count_in_hex: assert property (@(posedge clk) disable iff (rst)
    hex_count != 2'd0 |-> mode == MODE_HEX)
    else $error("hex digit count set outside hex mode");

  // Every command written leaves the decoder in normal mode.
  a_wr_normal: assert property (@(posedge clk) disable iff (rst)
    q_wr |=> mode == MODE_NORMAL)
    else $error("mode not normal after a command");

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_wr |-> !q_full)
    else $error("command written while queue full");

endmodule

/* rtl/core/jsu_fifo.sv */
// ----------------------------------------------------------------------------
// jsu_fifo
// Short command queue between the front end and the back end, held in
// registers and read at the head only.
// ----------------------------------------------------------------------------
module jsu_fifo import jsu_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_cmd,
  input  logic rd,
  output cmd_t head,
  output logic full,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CNT_FULL);
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (wr && !rd) begin
        count <= count + CW'(1);
      end else if (rd && !wr) begin
        count <= count - CW'(1);
      end
    end
  end

  // The fill count stays within the queue depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count beyond depth");

  // The back end reads only a command that is there.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> !empty)
    else $error("queue read while empty");

  // A lone write grows the queue by one entry.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    wr && !rd |=> count == $past(count) + CW'(1))
    else $error("queue count did not follow a write");

endmodule

/* rtl/core/jsu_back.sv */
// ----------------------------------------------------------------------------
// jsu_back
// Expands each queued command into one to three result items and holds the
// oldest result in an output register until it is taken.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      head,
  input  logic      q_empty,
  output logic      q_rd,
  input  logic      pop,
  output logic      empty,
  output out_item_t result
);

  logic       res_valid;
  logic [1:0] idx;
  logic       load;
  logic       last_of_cmd;
  logic [1:0] len;

  assign len         = cmd_len(head);
  assign last_of_cmd = (idx == len - 2'd1);
  assign load        = !res_valid || pop;
  assign q_rd        = load && !q_empty && last_of_cmd;
  assign empty       = !res_valid;

  // Output register: refilled whenever it is free or being taken.
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      result.out_byte <= cmd_byte(head, idx);
      result.kind     <= cmd_kind(head);
      result.last     <= last_of_cmd;
    end
  end

  // Valid flag and position within the current command.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      res_valid <= !q_empty;
      if (!q_empty) begin
        idx <= last_of_cmd ? 2'd0 : idx + 2'd1;
      end
    end
  end

  // A close or error mark is always the only result of its item.
  a_mark_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && result.kind != KIND_DATA |-> result.last)
    else $error("close or error result not marked last");

  // No command expands into more than three results.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx != 2'd3)
    else $error("result position out of range");

endmodule

/* rtl/core/json_string_unescape.sv */
// ----------------------------------------------------------------------------
// json_string_unescape
// Decodes a JSON string body one byte per item into bytes, UTF-8 sequences
// for unicode escapes, string-closed marks and parse errors.
// ----------------------------------------------------------------------------
// Path: an accepted item is written into the command queue; its results are
// then loaded into the output register whenever that register is free or taken.
// Throughput: one item per cycle unless the queue is full; the output register
// gives one result per cycle while popped, once per UTF-8 byte of an escape.
// Reset (rst, synchronous): returns to normal mode, empties the command queue
// and the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module json_string_unescape import jsu_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  raw,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic q_wr, q_rd, q_full, q_empty;
  cmd_t q_cmd, q_head;

  assign full = q_full;

  // Front end: mode tracking and classification.
  jsu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .raw    (raw),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_cmd  (q_cmd)
  );

  // Command queue.
  jsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_cmd (q_cmd),
    .rd     (q_rd),
    .head   (q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  // Back end: result expansion and output register.
  jsu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

/* tb/tb_json_string_unescape.sv */
// ----------------------------------------------------------------------------
// tb_json_string_unescape
// Self-checking bench for the JSON string body decoder. A short directed run
// covers the byte extremes, control bytes, escapes, unicode escapes of two and
// three UTF-8 bytes and the malformed cases. A random run follows: mostly
// well-formed string bodies, plus noise bytes, broken escapes and
// end-of-stream marks. A bench-side decoder predicts each result item. The
// sender works in bursts, and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_json_string_unescape;
  import jsu_pkg::*;

  localparam int RANDOM_ITEMS = 150;
  localparam int IDLE_LIMIT   = 2000;

  // One queued stimulus entry; a drain entry makes the sender wait until
  // every predicted result item has been taken.
  typedef struct {
    bit       drain_first;
    in_item_t item;
  } feed_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_MOSTLY,
    POP_RARELY,
    POP_EVERY_FOURTH
  } pop_style_t;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      push  = 1'b0;
  logic      full;
  in_item_t  raw   = '0;
  logic      empty;
  logic      pop   = 1'b0;
  out_item_t result;

  feed_t     body_bytes[$];
  out_item_t decoded_q[$];
  int        n_items    = 0;
  int        n_errors   = 0;
  int        burst_left = 8;
  int        gap_left   = 0;
  int        idle_count = 0;
  int        style_left = 0;
  int        pop_tick   = 0;
  pop_style_t pop_style = POP_ALWAYS;

  // Decoder state of the bench-side predictor.
  mode_t       dec_mode = MODE_NORMAL;
  logic [1:0]  hex_seen = 2'd0;
  logic [11:0] code_acc = 12'd0;

  json_string_unescape u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .raw    (raw),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #5 clk = ~clk;

  // Value of a hex digit in the low nibble; bit 4 set when not a hex digit.
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return {1'b0, c[3:0]};
    end
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      return {1'b0, c[3:0] + 4'd9};
    end
    return 5'h10;
  endfunction

  // Hex digit character for a nibble, in either letter case.
  function automatic logic [7:0] hex_char(logic [3:0] nib, bit lower);
    if (nib < 4'd10) begin
      return {4'h3, nib};
    end
    return (lower ? 8'h60 : 8'h40) + {4'h0, nib - 4'd9};
  endfunction

  // Predict the result items that one accepted item causes.
  task automatic decode_byte(in_item_t it);
    out_item_t outs[$];
    out_item_t r;
    logic [4:0]  nib;
    logic [15:0] cp;
    r = '0;
    r.kind = KIND_DATA;
    if (it.stream_end) begin
      dec_mode = MODE_NORMAL;
      hex_seen = 2'd0;
      code_acc = 12'd0;
      r.kind = KIND_ERROR;
      outs.insert(outs.size(), r);
    end else begin
      case (dec_mode)
        MODE_ESC: begin
          dec_mode = MODE_NORMAL;
          hex_seen = 2'd0;
          code_acc = 12'd0;
          case (it.in_byte)
            "\"", "\\", "/": r.out_byte = it.in_byte;
            "b": r.out_byte = 8'h08;
            "f": r.out_byte = 8'h0c;
            "n": r.out_byte = 8'h0a;
            "r": r.out_byte = 8'h0d;
            "t": r.out_byte = 8'h09;
            "u": dec_mode = MODE_HEX;
            default: r.kind = KIND_ERROR;
          endcase
          if (dec_mode != MODE_HEX) begin
            outs.insert(outs.size(), r);
          end
        end
        MODE_HEX: begin
          nib = hex_nibble(it.in_byte);
          if (nib[4]) begin
            dec_mode = MODE_NORMAL;
            hex_seen = 2'd0;
            code_acc = 12'd0;
            r.kind = KIND_ERROR;
            outs.insert(outs.size(), r);
          end else if (hex_seen != 2'd3) begin
            code_acc = {code_acc[7:0], nib[3:0]};
            hex_seen = hex_seen + 2'd1;
          end else begin
            cp = {code_acc, nib[3:0]};
            dec_mode = MODE_NORMAL;
            hex_seen = 2'd0;
            code_acc = 12'd0;
            // Encode the code point as UTF-8 of one to three bytes.
            if (cp < 16'h0080) begin
              r.out_byte = cp[7:0];
              outs.insert(outs.size(), r);
            end else if (cp < 16'h0800) begin
              r.out_byte = {3'b110, cp[10:6]};
              outs.insert(outs.size(), r);
              r.out_byte = {2'b10, cp[5:0]};
              outs.insert(outs.size(), r);
            end else begin
              r.out_byte = {4'b1110, cp[15:12]};
              outs.insert(outs.size(), r);
              r.out_byte = {2'b10, cp[11:6]};
              outs.insert(outs.size(), r);
              r.out_byte = {2'b10, cp[5:0]};
              outs.insert(outs.size(), r);
            end
          end
        end
        default: begin
          if (it.in_byte == "\"") begin
            r.kind = KIND_CLOSED;
            outs.insert(outs.size(), r);
          end else if (it.in_byte == "\\") begin
            dec_mode = MODE_ESC;
          end else if (it.in_byte < 8'd32 || it.in_byte == 8'd127) begin
            r.kind = KIND_ERROR;
            outs.insert(outs.size(), r);
          end else begin
            r.out_byte = it.in_byte;
            outs.insert(outs.size(), r);
          end
        end
      endcase
    end
    // Flag the final result item of this input item.
    if (outs.size() != 0) begin
      r = outs.pop_back();
      r.last = 1'b1;
      outs.insert(outs.size(), r);
    end
    foreach (outs[i]) begin
      decoded_q.insert(decoded_q.size(), outs[i]);
    end
  endtask

  task automatic feed_byte(logic [7:0] b);
    feed_t f;
    f.drain_first = 1'b0;
    f.item.in_byte = b;
    f.item.stream_end = 1'b0;
    body_bytes.insert(body_bytes.size(), f);
    n_items++;
  endtask

  task automatic feed_end();
    feed_t f;
    f.drain_first = 1'b0;
    f.item.in_byte = 8'($urandom_range(0, 255));
    f.item.stream_end = 1'b1;
    body_bytes.insert(body_bytes.size(), f);
    n_items++;
  endtask

  task automatic feed_drain();
    feed_t f;
    f.drain_first = 1'b1;
    f.item = '0;
    body_bytes.insert(body_bytes.size(), f);
  endtask

  task automatic feed_escape(logic [7:0] letter);
    feed_byte("\\");
    feed_byte(letter);
  endtask

  // Backslash, u, then the first n_digits hex digits of cp in random case.
  task automatic feed_hex_prefix(logic [15:0] cp, int n_digits);
    feed_byte("\\");
    feed_byte("u");
    for (int i = 0; i < n_digits; i++) begin
      feed_byte(hex_char(cp[15 - 4 * i -: 4], 1'($urandom_range(0, 1))));
    end
  endtask

  // A random byte that is not a hex digit.
  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    logic [4:0] nib;
    do begin
      c = 8'($urandom_range(0, 255));
      nib = hex_nibble(c);
    end while (!nib[4]);
    return c;
  endfunction

  // Sender: takes items from the stimulus queue in bursts with gaps.
  always @(posedge clk) begin : driver
    feed_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_byte(raw);
      end
      if (push && full) begin
        // Hold the item until it is taken.
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        push <= 1'b0;
      end else if (body_bytes.size() == 0) begin
        push <= 1'b0;
      end else if (body_bytes[0].drain_first) begin
        push <= 1'b0;
        if (decoded_q.size() == 0) begin
          void'(body_bytes.pop_front());
        end
      end else begin
        nxt = body_bytes.pop_front();
        raw <= nxt.item;
        push <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: checks each taken result item and stalls in changing patterns.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result item, expected none, actual %h", $time, result);
        end else begin
          want = decoded_q.pop_front();
          if (result.out_byte !== want.out_byte) begin
            n_errors++;
            $display("%0t: out_byte mismatch, expected %h, actual %h",
                     $time, want.out_byte, result.out_byte);
          end
          if (result.kind !== want.kind) begin
            n_errors++;
            $display("%0t: kind mismatch, expected %0d, actual %0d",
                     $time, want.kind, result.kind);
          end
          if (result.last !== want.last) begin
            n_errors++;
            $display("%0t: last mismatch, expected %b, actual %b",
                     $time, want.last, result.last);
          end
        end
      end
      if (style_left == 0) begin
        pop_style <= pop_style_t'($urandom_range(0, 3));
        style_left <= $urandom_range(20, 80);
      end else begin
        style_left <= style_left - 1;
      end
      pop_tick <= pop_tick + 1;
      case (pop_style)
        POP_ALWAYS: pop <= 1'b1;
        POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
        POP_RARELY: pop <= ($urandom_range(0, 3) == 0);
        default:    pop <= (pop_tick % 4 == 3);
      endcase
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_count <= 0;
      end else begin
        idle_count <= idle_count + 1;
      end
      if (idle_count >= IDLE_LIMIT) begin
        $display("json_string_unescape test failed");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int          goal;
    int          pick;
    int          k;
    logic [15:0] cp;
    logic [7:0]  c;
    string       esc_letters;
    esc_letters = "\"\\/bfnrt";

    // Directed part: extremes, control bytes, escapes and broken sequences.
    feed_byte(8'h20);
    feed_byte(8'hff);
    feed_byte(8'h00);
    feed_byte(8'h7f);
    feed_byte("\"");
    feed_escape("\"");
    feed_escape("\\");
    feed_hex_prefix(16'hffff, 4);
    feed_hex_prefix(16'h00e9, 4);
    feed_escape("q");
    feed_hex_prefix(16'h1000, 1);
    feed_byte("z");
    feed_end();
    feed_drain();

    // Random part: mostly well-formed bodies with random content.
    goal = n_items + RANDOM_ITEMS;
    while (n_items < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        do begin
          c = 8'($urandom_range(32, 255));
        end while (c == "\"" || c == "\\" || c == 8'h7f);
        feed_byte(c);
      end else if (pick < 55) begin
        feed_escape(esc_letters[$urandom_range(0, 7)]);
      end else if (pick < 70) begin
        case ($urandom_range(0, 2))
          0:       cp = 16'($urandom_range(16'h0000, 16'h007f));
          1:       cp = 16'($urandom_range(16'h0080, 16'h07ff));
          default: cp = 16'($urandom_range(16'h0800, 16'hffff));
        endcase
        feed_hex_prefix(cp, 4);
      end else if (pick < 78) begin
        feed_byte("\"");
      end else if (pick < 86) begin
        feed_byte(8'($urandom_range(0, 255)));
      end else if (pick < 96) begin
        cp = 16'($urandom_range(0, 16'hffff));
        k = $urandom_range(0, 3);
        case ($urandom_range(0, 2))
          0: begin
            // Escape letter that is not valid.
            do begin
              c = 8'($urandom_range(0, 255));
            end while (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                       c == "n" || c == "r" || c == "t" || c == "u");
            feed_escape(c);
          end
          1: begin
            feed_hex_prefix(cp, k);
            feed_byte(non_hex_byte());
          end
          default: begin
            // Stream ends in the middle of an escape.
            if ($urandom_range(0, 1) == 0) begin
              feed_byte("\\");
            end else begin
              feed_hex_prefix(cp, k);
            end
            feed_end();
          end
        endcase
      end else if (pick < 98) begin
        feed_end();
      end else begin
        feed_drain();
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do begin
      @(posedge clk);
    end while (body_bytes.size() != 0 || push || decoded_q.size() != 0);
    repeat (10) @(posedge clk);

    if (n_errors == 0 && decoded_q.size() == 0) begin
      $display("json_string_unescape test passed");
    end else begin
      $display("json_string_unescape test failed");
    end
    $finish;
  end

endmodule

/* json_string_unescape.f */
rtl/core/jsu_pkg.sv
rtl/core/jsu_front.sv
rtl/core/jsu_fifo.sv
rtl/core/jsu_back.sv
rtl/core/json_string_unescape.sv
tb/tb_json_string_unescape.sv
